@@ rtl/core/lbe_pkg.sv @@
package lbe_pkg;

	localparam int MAX_POINTS = 16;
	localparam int PT_AW      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic signed [35:0] S24_MAX = 36'sd8388607;
	localparam logic signed [35:0] S24_MIN = -36'sd8388608;

	localparam int MOD_STEPS = 32;
	localparam int DIV_STEPS = 17;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_EVAL = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_LOOP_LENGTH = 2'd1,
		REG_RANGE_LOW   = 2'd2,
		REG_RANGE_HIGH  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] at;
		logic [16:0] level;
	} bp_entry_t;

	localparam int ENTRY_W = $bits(bp_entry_t);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_MOD   = 13'b0000000000010,
		ST_FIRST = 13'b0000000000100,
		ST_LAST  = 13'b0000000001000,
		ST_CHKL  = 13'b0000000010000,
		ST_SREQ  = 13'b0000000100000,
		ST_SCHK  = 13'b0000001000000,
		ST_MUL1  = 13'b0000010000000,
		ST_DSET  = 13'b0000100000000,
		ST_DIV   = 13'b0001000000000,
		ST_FIX   = 13'b0010000000000,
		ST_MUL2  = 13'b0100000000000,
		ST_OUT   = 13'b1000000000000
	} state_t;

endpackage

@@ rtl/core/lbe_ram.sv @@
module lbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/looped_breakpoint_envelope.sv @@
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// item in  | start & !busy        | kind, point_index, point_time, point_level,
//          |                      | query_time
// result   | done (1-cycle pulse) | unipolar_level, scaled_level, table_empty
// config   | cfg_write            | cfg_index, cfg_data
//
// A load item is written to the table in the accept cycle; busy stays low.
// An evaluate item holds busy through a 32-step bit-serial wrap
// (only when loop_length is non-zero), a scan over the stored breakpoints,
// and 17 steps of the same compare/subtract unit for the interpolation divide.
// done pulses in the same cycle that busy falls; an empty table answers in the next cycle without busy.
// arst_n clears control state, config and result registers; the table is undefined until written.
// Results cannot be stalled.
module looped_breakpoint_envelope (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [3:0]         point_index,
	input  logic [31:0]        point_time,
	input  logic [16:0]        point_level,
	input  logic [31:0]        query_time,
	output logic               done,
	output logic [16:0]        unipolar_level,
	output logic signed [23:0] scaled_level,
	output logic               table_empty,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	lbe_pkg::state_t state_q;

	logic [4:0]         point_count_q;
	logic [31:0]        loop_length_q;
	logic signed [23:0] range_low_q;
	logic signed [23:0] range_high_q;

	logic [31:0] ct_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [16:0] quo_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [16:0] u_q;
	logic signed [50:0] prod_q;
	logic [lbe_pkg::PT_AW-1:0] idx_q;
	lbe_pkg::bp_entry_t prev_q;
	lbe_pkg::bp_entry_t segb_q;

	logic               done_q;
	logic [16:0]        unipolar_q;
	logic signed [23:0] scaled_q;
	logic               empty_q;

	// table
	logic                      ram_we;
	logic [lbe_pkg::PT_AW-1:0] ram_waddr;
	lbe_pkg::bp_entry_t        ram_wdata;
	logic [lbe_pkg::PT_AW-1:0] ram_raddr;
	lbe_pkg::bp_entry_t        ram_rdata;

	logic                      accept;
	logic [lbe_pkg::CNT_W-1:0] n_eff;
	logic [lbe_pkg::PT_AW-1:0] n_last;

	assign accept = start && !busy;
	assign busy   = (state_q != lbe_pkg::ST_IDLE);

	assign n_eff = (32'(point_count_q) > 32'(lbe_pkg::MAX_POINTS)) ?
		lbe_pkg::CNT_W'(lbe_pkg::MAX_POINTS) : lbe_pkg::CNT_W'(point_count_q);
	assign n_last = lbe_pkg::PT_AW'(n_eff - lbe_pkg::CNT_W'(1));

	assign ram_we    = accept && (kind == lbe_pkg::KIND_LOAD) &&
		(32'(point_index) < 32'(lbe_pkg::MAX_POINTS));
	assign ram_waddr = lbe_pkg::PT_AW'(point_index);
	assign ram_wdata.at    = point_time;
	assign ram_wdata.level = (point_level > lbe_pkg::ONE_Q16) ? lbe_pkg::ONE_Q16 : point_level;

	always_comb begin
		ram_raddr = '0;
		if (state_q == lbe_pkg::ST_LAST) begin
			ram_raddr = n_last;
		end else if (state_q == lbe_pkg::ST_SREQ) begin
			ram_raddr = idx_q;
		end
	end

	lbe_ram #(
		.WIDTH(lbe_pkg::ENTRY_W),
		.DEPTH(lbe_pkg::MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared restoring divide step: remainder shifts in the next dividend bit
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;
	logic [31:0] rem_nx;

	assign trial  = {rem_q, dvd_q[31]};
	assign diff   = trial - {1'b0, dsr_q};
	assign ge     = (trial >= {1'b0, dsr_q});
	assign rem_nx = ge ? diff[31:0] : trial[31:0];

	// shared multiplier: level delta * offset, then level * range span
	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [50:0] mul_p;
	logic signed [24:0] span_rng;
	logic [31:0]        off;

	assign span_rng = {range_high_q[23], range_high_q} - {range_low_q[23], range_low_q};
	assign off      = ct_q - prev_q.at;

	always_comb begin
		if (state_q == lbe_pkg::ST_MUL1) begin
			mul_a = {1'b0, segb_q.level} - {1'b0, prev_q.level};
			mul_b = {1'b0, off};
		end else begin
			mul_a = {1'b0, u_q};
			mul_b = {{8{span_rng[24]}}, span_rng};
		end
	end

	assign mul_p = mul_a * mul_b;

	// magnitude for the divide, floor correction afterward
	logic [50:0]        mag;
	logic [17:0]        qmag;
	logic signed [18:0] frac;
	logic signed [18:0] rsum;
	logic [16:0]        r_clamped;

	assign mag  = prod_q[50] ? 51'(-prod_q) : 51'(prod_q);
	assign qmag = {1'b0, quo_q} + {17'd0, (neg_q && (rem_q != 32'd0))};
	assign frac = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
	assign rsum = $signed({2'b00, prev_q.level}) + frac;

	always_comb begin
		if (rsum[18]) begin
			r_clamped = '0;
		end else if (rsum[17:0] > {1'b0, lbe_pkg::ONE_Q16}) begin
			r_clamped = lbe_pkg::ONE_Q16;
		end else begin
			r_clamped = rsum[16:0];
		end
	end

	// range mapping: floor(u * span / 65536) is an arithmetic shift
	logic signed [35:0] s_sum;
	logic signed [23:0] s_sat;

	assign s_sum = {{12{range_low_q[23]}}, range_low_q} + {prod_q[50], prod_q[50:16]};

	always_comb begin
		if (s_sum > lbe_pkg::S24_MAX) begin
			s_sat = 24'sh7FFFFF;
		end else if (s_sum < lbe_pkg::S24_MIN) begin
			s_sat = -24'sh800000;
		end else begin
			s_sat = s_sum[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			loop_length_q <= '0;
			range_low_q   <= '0;
			range_high_q  <= 24'sd256;
		end else if (cfg_write) begin
			unique case (lbe_pkg::cfg_reg_t'(cfg_index))
				lbe_pkg::REG_POINT_COUNT: point_count_q <= cfg_data[4:0];
				lbe_pkg::REG_LOOP_LENGTH: loop_length_q <= cfg_data;
				lbe_pkg::REG_RANGE_LOW:   range_low_q   <= cfg_data[23:0];
				lbe_pkg::REG_RANGE_HIGH:  range_high_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lbe_pkg::ST_IDLE;
			done_q     <= 1'b0;
			empty_q    <= 1'b0;
			unipolar_q <= '0;
			scaled_q   <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				lbe_pkg::ST_IDLE: begin
					if (accept && (kind == lbe_pkg::KIND_EVAL)) begin
						if (n_eff == '0) begin
							done_q     <= 1'b1;
							empty_q    <= 1'b1;
							unipolar_q <= '0;
							scaled_q   <= '0;
						end else if (loop_length_q != 32'd0) begin
							rem_q   <= '0;
							dvd_q   <= query_time;
							dsr_q   <= loop_length_q;
							cnt_q   <= 6'(lbe_pkg::MOD_STEPS);
							state_q <= lbe_pkg::ST_MOD;
						end else begin
							ct_q    <= query_time;
							state_q <= lbe_pkg::ST_FIRST;
						end
					end
				end
				lbe_pkg::ST_MOD: begin
					rem_q <= rem_nx;
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						ct_q    <= rem_nx;
						state_q <= lbe_pkg::ST_FIRST;
					end
				end
				lbe_pkg::ST_FIRST: begin
					state_q <= lbe_pkg::ST_LAST;
				end
				lbe_pkg::ST_LAST: begin
					// entry 0 on the read port
					prev_q <= ram_rdata;
					if (ct_q <= ram_rdata.at) begin
						u_q     <= ram_rdata.level;
						state_q <= lbe_pkg::ST_MUL2;
					end else begin
						state_q <= lbe_pkg::ST_CHKL;
					end
				end
				lbe_pkg::ST_CHKL: begin
					// last entry on the read port
					if (ct_q >= ram_rdata.at) begin
						u_q     <= ram_rdata.level;
						state_q <= lbe_pkg::ST_MUL2;
					end else begin
						idx_q   <= lbe_pkg::PT_AW'(1);
						state_q <= lbe_pkg::ST_SREQ;
					end
				end
				lbe_pkg::ST_SREQ: begin
					state_q <= lbe_pkg::ST_SCHK;
				end
				lbe_pkg::ST_SCHK: begin
					// ct < last time, so the scan always stops by the last entry
					if (ct_q < ram_rdata.at) begin
						segb_q  <= ram_rdata;
						state_q <= lbe_pkg::ST_MUL1;
					end else begin
						prev_q  <= ram_rdata;
						idx_q   <= idx_q + lbe_pkg::PT_AW'(1);
						state_q <= lbe_pkg::ST_SREQ;
					end
				end
				lbe_pkg::ST_MUL1: begin
					prod_q  <= mul_p;
					dsr_q   <= segb_q.at - prev_q.at;
					state_q <= lbe_pkg::ST_DSET;
				end
				lbe_pkg::ST_DSET: begin
					// |delta * off| < 2^17 * span, so the top part is already below span
					neg_q   <= prod_q[50];
					rem_q   <= mag[48:17];
					dvd_q   <= {mag[16:0], 15'd0};
					cnt_q   <= 6'(lbe_pkg::DIV_STEPS);
					state_q <= lbe_pkg::ST_DIV;
				end
				lbe_pkg::ST_DIV: begin
					rem_q <= rem_nx;
					dvd_q <= {dvd_q[30:0], 1'b0};
					quo_q <= {quo_q[15:0], ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= lbe_pkg::ST_FIX;
					end
				end
				lbe_pkg::ST_FIX: begin
					u_q     <= r_clamped;
					state_q <= lbe_pkg::ST_MUL2;
				end
				lbe_pkg::ST_MUL2: begin
					prod_q  <= mul_p;
					state_q <= lbe_pkg::ST_OUT;
				end
				lbe_pkg::ST_OUT: begin
					done_q     <= 1'b1;
					empty_q    <= 1'b0;
					unipolar_q <= u_q;
					scaled_q   <= s_sat;
					state_q    <= lbe_pkg::ST_IDLE;
				end
				default: begin
					state_q <= lbe_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign unipolar_level = unipolar_q;
	assign scaled_level   = scaled_q;
	assign table_empty    = empty_q;

endmodule

@@ rtl/core/lbe_checker.sv @@
module lbe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               kind,
	input logic               done,
	input logic [16:0]        unipolar_level,
	input logic signed [23:0] scaled_level,
	input logic               table_empty
);

	// a result only appears once the sequencer has let go
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_empty) |-> (unipolar_level == 17'd0 && scaled_level == 24'sd0))
		else $error("empty table result not zero");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (unipolar_level <= 17'h10000))
		else $error("unipolar level above one");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> (!busy && !done))
		else $error("load item started work or gave a result");

	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind) |=> (busy || done))
		else $error("evaluate item dropped");

endmodule

bind looped_breakpoint_envelope lbe_checker u_lbe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.done          (done),
	.unipolar_level(unipolar_level),
	.scaled_level  (scaled_level),
	.table_empty   (table_empty)
);

@@ test/looped_breakpoint_envelope_tb.sv @@
module looped_breakpoint_envelope_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 450;
	localparam int TAIL_CYCLES  = 100;

	typedef struct packed {
		logic [16:0]        unipolar;
		logic signed [23:0] scaled;
		logic               empty;
	} level_out_t;

	typedef struct packed {
		logic              is_write;
		lbe_pkg::cfg_reg_t reg_sel;
		logic [31:0]       wdata;
		lbe_pkg::kind_t    op;
		logic [3:0]        slot;
		logic [31:0]       ptime;
		logic [16:0]       plevel;
		logic [31:0]       qtime;
		logic              fixed;
		level_out_t        want;
	} step_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               kind;
	logic [3:0]         point_index;
	logic [31:0]        point_time;
	logic [16:0]        point_level;
	logic [31:0]        query_time;
	logic               done;
	logic [16:0]        unipolar_level;
	logic signed [23:0] scaled_level;
	logic               table_empty;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	// expectation typed into the directed table rides along with the item
	logic       has_fixed;
	level_out_t fixed_want;

	logic [31:0]        bp_time [lbe_pkg::MAX_POINTS];
	logic [16:0]        bp_level[lbe_pkg::MAX_POINTS];
	logic [4:0]         point_num;
	logic [31:0]        loop_len;
	logic signed [23:0] range_lo;
	logic signed [23:0] range_hi;

	level_out_t pending_levels[$];
	int         errors;
	int         stall_cycles;
	int         sent_items;
	bit         steady;

	looped_breakpoint_envelope dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.point_index   (point_index),
		.point_time    (point_time),
		.point_level   (point_level),
		.query_time    (query_time),
		.done          (done),
		.unipolar_level(unipolar_level),
		.scaled_level  (scaled_level),
		.table_empty   (table_empty),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint floor_div(longint num, longint den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic logic [16:0] interp_level(logic [31:0] q, int n);
		logic [31:0] ct;
		longint la, lb, ta, tb, cl, r;
		int i;
		ct = (loop_len != 0) ? q % loop_len : q;
		if (ct <= bp_time[0])
			return bp_level[0];
		if (ct >= bp_time[n-1])
			return bp_level[n-1];
		for (i = 1; i < n; i++) begin
			if (ct < bp_time[i]) begin
				la = bp_level[i-1];
				lb = bp_level[i];
				ta = bp_time[i-1];
				tb = bp_time[i];
				cl = ct;
				r  = la;
				if (tb - ta > 0 && cl - ta > 0)
					r = la + floor_div((lb - la) * (cl - ta), tb - ta);
				if (r < 0)
					r = 0;
				if (r > 65536)
					r = 65536;
				return r[16:0];
			end
		end
		return bp_level[n-1];
	endfunction

	function automatic level_out_t envelope_at(logic [31:0] q);
		level_out_t res;
		int n;
		longint u, lo, hi, s;
		n = (point_num > lbe_pkg::MAX_POINTS) ? lbe_pkg::MAX_POINTS : point_num;
		res = '0;
		if (n == 0) begin
			res.empty = 1'b1;
			return res;
		end
		res.unipolar = interp_level(q, n);
		u  = res.unipolar;
		lo = range_lo;
		hi = range_hi;
		s  = lo + floor_div(u * (hi - lo), 65536);
		if (s > 8388607)
			s = 8388607;
		if (s < -8388608)
			s = -8388608;
		res.scaled = s[23:0];
		return res;
	endfunction

	function automatic step_row_t ld(logic [3:0] s, logic [31:0] t, logic [16:0] l);
		step_row_t row;
		row = '0;
		row.op = lbe_pkg::KIND_LOAD;
		row.slot = s;
		row.ptime = t;
		row.plevel = l;
		return row;
	endfunction

	function automatic step_row_t ev(logic [31:0] q);
		step_row_t row;
		row = '0;
		row.op = lbe_pkg::KIND_EVAL;
		row.qtime = q;
		return row;
	endfunction

	function automatic step_row_t evx(logic [31:0] q, logic [16:0] u, logic signed [23:0] sc,
			logic e);
		step_row_t row;
		row = ev(q);
		row.fixed = 1'b1;
		row.want.unipolar = u;
		row.want.scaled = sc;
		row.want.empty = e;
		return row;
	endfunction

	function automatic step_row_t wr(lbe_pkg::cfg_reg_t r, logic [31:0] d);
		step_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_sel = r;
		row.wdata = d;
		return row;
	endfunction

	function automatic logic [16:0] rand_level();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 17'd0;
		if (r == 1)
			return lbe_pkg::ONE_Q16;
		if (r == 2)
			return 17'($urandom_range(65537, 131071));
		return 17'($urandom_range(0, 65536));
	endfunction

	// checker, predictor update and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_levels.size() == 0) begin
					$display("%0t: result with nothing expected: u=%0d s=%0d empty=%0b",
						$time, unipolar_level, scaled_level, table_empty);
					errors++;
				end else begin
					level_out_t w;
					w = pending_levels.pop_front();
					if (unipolar_level !== w.unipolar) begin
						$display("%0t: unipolar_level expected %0d got %0d",
							$time, w.unipolar, unipolar_level);
						errors++;
					end
					if (scaled_level !== w.scaled) begin
						$display("%0t: scaled_level expected %0d got %0d",
							$time, w.scaled, scaled_level);
						errors++;
					end
					if (table_empty !== w.empty) begin
						$display("%0t: table_empty expected %0b got %0b",
							$time, w.empty, table_empty);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (kind == lbe_pkg::KIND_LOAD) begin
					bp_time[point_index]  = point_time;
					bp_level[point_index] = (point_level > lbe_pkg::ONE_Q16) ?
						lbe_pkg::ONE_Q16 : point_level;
				end else begin
					pending_levels.push_back(has_fixed ? fixed_want : envelope_at(query_time));
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					lbe_pkg::REG_POINT_COUNT: point_num = cfg_data[4:0];
					lbe_pkg::REG_LOOP_LENGTH: loop_len = cfg_data;
					lbe_pkg::REG_RANGE_LOW:   range_lo = cfg_data[23:0];
					lbe_pkg::REG_RANGE_HIGH:  range_hi = cfg_data[23:0];
					default: ;
				endcase
			end
		end
		if ((start && !busy) || done || cfg_write)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[looped_breakpoint_envelope] ERROR");
			$finish;
		end
	end

	task automatic send_item(step_row_t row);
		while (!steady && $urandom_range(0, 99) < 7) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start       <= 1'b1;
		kind        <= row.op;
		point_index <= row.slot;
		point_time  <= row.ptime;
		point_level <= row.plevel;
		query_time  <= row.qtime;
		has_fixed   <= row.fixed;
		fixed_want  <= row.want;
		do
			@(posedge clk);
		while (busy);
		sent_items++;
	endtask

	task automatic write_reg(lbe_pkg::cfg_reg_t r, logic [31:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// block idle: no item in flight, no result owed
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_levels.size() != 0 || busy)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	initial begin
		step_row_t   plan[$];
		logic [31:0] tt[lbe_pkg::MAX_POINTS];
		logic [31:0] step, ll, d;
		logic [4:0]  cnt;
		logic signed [23:0] lo, hi;
		longint      q_hi;
		int          r, k, m, off, ph;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = lbe_pkg::KIND_LOAD;
		point_index = '0;
		point_time = '0;
		point_level = '0;
		query_time = '0;
		cfg_write = 1'b0;
		cfg_index = lbe_pkg::REG_POINT_COUNT;
		cfg_data = '0;
		has_fixed = 1'b0;
		fixed_want = '0;
		errors = 0;
		stall_cycles = 0;
		sent_items = 0;
		steady = 1'b0;
		for (k = 0; k < lbe_pkg::MAX_POINTS; k++) begin
			bp_time[k] = '0;
			bp_level[k] = '0;
		end
		point_num = '0;
		loop_len = '0;
		range_lo = 24'sd0;
		range_hi = 24'sd256;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		plan.push_back(evx(32'h0, 17'd0, 24'sd0, 1'b1));
		plan.push_back(evx(32'hFFFFFFFF, 17'd0, 24'sd0, 1'b1));
		plan.push_back(ld(4'd0, 32'h0001_0000, 17'd0));
		plan.push_back(ld(4'd1, 32'h0002_0000, 17'h1FFFF));    // level saturates
		plan.push_back(ld(4'd2, 32'h0002_0000, 17'h08000));    // zero-length segment
		plan.push_back(ld(4'd3, 32'hFFFFFFFF, lbe_pkg::ONE_Q16));
		plan.push_back(wr(lbe_pkg::REG_POINT_COUNT, 32'd4));
		plan.push_back(evx(32'h0, 17'd0, 24'sd0, 1'b0));
		plan.push_back(evx(32'hFFFFFFFF, lbe_pkg::ONE_Q16, 24'sd256, 1'b0));
		plan.push_back(ev(32'h0001_8000));
		plan.push_back(ev(32'h0002_0000));
		plan.push_back(ev(32'h8000_0000));
		plan.push_back(wr(lbe_pkg::REG_RANGE_LOW, 32'h0080_0000));
		plan.push_back(wr(lbe_pkg::REG_RANGE_HIGH, 32'h007F_FFFF));
		plan.push_back(evx(32'hFFFFFFFF, lbe_pkg::ONE_Q16, 24'sh7FFFFF, 1'b0));
		plan.push_back(evx(32'h0, 17'd0, 24'sh800000, 1'b0));
		plan.push_back(wr(lbe_pkg::REG_RANGE_LOW, 32'h007F_FFFF));
		plan.push_back(wr(lbe_pkg::REG_RANGE_HIGH, 32'hFF80_0000));
		plan.push_back(ev(32'h0001_C000));
		plan.push_back(wr(lbe_pkg::REG_LOOP_LENGTH, 32'h0003_0000));
		plan.push_back(ev(32'h0004_8000));
		plan.push_back(ev(32'hFFFFFFFF));
		plan.push_back(wr(lbe_pkg::REG_LOOP_LENGTH, 32'hFFFFFFFF));
		plan.push_back(ev(32'hFFFFFFFF));
		plan.push_back(ld(4'd1, 32'h0, 17'h04000));            // table out of order
		plan.push_back(ev(32'h0001_8000));
		plan.push_back(ev(32'h0000_8000));
		plan.push_back(wr(lbe_pkg::REG_POINT_COUNT, 32'd1));
		plan.push_back(ev(32'h1234_5678));
		plan.push_back(wr(lbe_pkg::REG_POINT_COUNT, 32'd0));
		plan.push_back(evx(32'h5A5A_5A5A, 17'd0, 24'sd0, 1'b1));
		plan.push_back(ld(4'd15, 32'hFFFFFFFF, 17'h1FFFF));

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				settle();
				write_reg(plan[i].reg_sel, plan[i].wdata);
			end else begin
				send_item(plan[i]);
			end
		end

		// random phases; the first one fills every slot so no unwritten entry is read
		sent_items = 0;
		ph = 0;
		while (sent_items < RANDOM_ITEMS) begin
			settle();
			r = $urandom_range(0, 3);
			step = (r == 0) ? 32'd3 : (r == 1) ? 32'h100 : (r == 2) ? 32'h4_0000 : 32'h0FFF_FFFF;
			tt[0] = $urandom_range(0, 32'h1_0000);
			for (k = 1; k < lbe_pkg::MAX_POINTS; k++)
				tt[k] = tt[k-1] + (($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(0, step));
			q_hi = tt[lbe_pkg::MAX_POINTS-1];
			q_hi = q_hi + q_hi / 8 + 64;
			if (q_hi > 64'hFFFF_FFFF)
				q_hi = 64'hFFFF_FFFF;

			r = $urandom_range(0, 19);
			cnt = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 : (r == 2) ? 5'($urandom_range(17, 31)) :
				(r == 3) ? 5'd1 : 5'($urandom_range(2, 16));
			if (ph == 0)
				cnt = 5'd31;
			d = $urandom;
			d[4:0] = cnt;
			write_reg(lbe_pkg::REG_POINT_COUNT, d);

			r = $urandom_range(0, 9);
			ll = (r < 4) ? 32'd0 : (r < 7) ? $urandom_range(1, q_hi[31:0]) : (r == 7) ? 32'd1 :
				(r == 8) ? 32'hFFFFFFFF : $urandom;
			write_reg(lbe_pkg::REG_LOOP_LENGTH, ll);

			r = $urandom_range(0, 5);
			lo = 24'($urandom);
			hi = 24'($urandom);
			if (r == 0) begin
				lo = 24'sh800000;
				hi = 24'sh7FFFFF;
			end else if (r == 1) begin
				lo = 24'sh7FFFFF;
				hi = 24'sh800000;
			end else if (r == 2) begin
				hi = lo;
			end
			d = $urandom;
			d[23:0] = lo;
			write_reg(lbe_pkg::REG_RANGE_LOW, d);
			d = $urandom;
			d[23:0] = hi;
			write_reg(lbe_pkg::REG_RANGE_HIGH, d);

			steady = (ph % 5 == 2);
			if (ph == 0 || $urandom_range(0, 4) != 0) begin
				off = $urandom_range(0, lbe_pkg::MAX_POINTS - 1);
				for (k = 0; k < lbe_pkg::MAX_POINTS; k++)
					send_item(ld(4'((k + off) % lbe_pkg::MAX_POINTS),
						tt[(k + off) % lbe_pkg::MAX_POINTS], rand_level()));
			end else begin
				m = $urandom_range(3, 6);
				for (k = 0; k < m; k++)
					send_item(ld(4'($urandom_range(0, 15)), $urandom,
						17'($urandom_range(0, 131071))));
			end

			m = $urandom_range(12, 18);
			for (k = 0; k < m; k++) begin
				if ($urandom_range(0, 11) == 0)
					send_item(ld(4'($urandom_range(0, 15)), $urandom,
						17'($urandom_range(0, 131071))));
				r = $urandom_range(0, 19);
				if (r < 14)
					send_item(ev($urandom_range(0, q_hi[31:0])));
				else if (r < 16)
					send_item(ev(tt[$urandom_range(0, lbe_pkg::MAX_POINTS - 1)]));
				else if (r < 19)
					send_item(ev($urandom));
				else
					send_item(ev($urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0));
			end
			ph++;
		end

		steady = 1'b0;
		@(negedge clk);
		start <= 1'b0;
		while (pending_levels.size() != 0 || busy)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[looped_breakpoint_envelope] OK");
		else
			$display("[looped_breakpoint_envelope] ERROR");
		$finish;
	end

endmodule
